@@ hw/rtl/necd_pkg.sv @@
// Shared widths, register indexes, reset values and status codes for the NEC IR frame decoder.
package necd_pkg;

  // Field widths
  localparam int TICKS_W    = 15;
  localparam int DUR_W      = 16;
  localparam int TOL_W      = 12;
  localparam int CMD_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = 6;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Tick rate default
  localparam int TICKS_PER_10US_DEFAULT = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_TOL      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_TOL   = 3'd6;

  // Register reset values (standard NEC timing)
  localparam logic [DUR_W-1:0] HEADER_MARK_RST  = 16'd9000;
  localparam logic [DUR_W-1:0] HEADER_SPACE_RST = 16'd4500;
  localparam logic [DUR_W-1:0] BIT_MARK_RST     = 16'd560;
  localparam logic [DUR_W-1:0] ONE_SPACE_RST    = 16'd1690;
  localparam logic [DUR_W-1:0] ZERO_SPACE_RST   = 16'd560;
  localparam logic [TOL_W-1:0] BIT_TOL_RST      = 12'd100;
  localparam logic [TOL_W-1:0] HEADER_TOL_RST   = 12'd200;

  // Symbol positions within a frame
  localparam logic [IDX_W-1:0] SYM_HEADER    = 6'd0;
  localparam logic [IDX_W-1:0] SYM_ADDR      = 6'd8;
  localparam logic [IDX_W-1:0] SYM_INV_ADDR  = 6'd16;
  localparam logic [IDX_W-1:0] SYM_CMD       = 6'd24;
  localparam logic [IDX_W-1:0] SYM_LAST_DATA = 6'd32;
  localparam logic [IDX_W-1:0] SYM_MAX       = 6'd63;

  localparam logic [CMD_W-1:0] BYTE_ONES = 8'hff;

  // Result status
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK              = 2'd0,
    STATUS_HEADER_MISMATCH = 2'd1,
    STATUS_COMPLEMENT_FAIL = 2'd2
  } necd_status_t;

endpackage

@@ hw/rtl/nec_ir_frame_decoder.sv @@
// Top level of the NEC IR frame decoder: handshake pipeline, window checks and frame state.
//
// Input stream: one captured IR symbol per transaction. tdata carries the mark and
// space durations in counter ticks, tlast flags the last symbol of a frame.
// Output stream: one transaction per frame, issued for the symbol carrying tlast.
// tdata is the command byte (0 when rejected), tuser the status code.
// Configuration: write-only register port (enable, index, data); write it only
// while no symbol is in flight. Unknown indexes are ignored.
// Pipeline: input register, converted-duration register (one multiplier per
// duration), then window checks and state update into the output register.
// m_axis_tvalid is registered, after the input and converted-duration registers.
// Throughput: one symbol per cycle barring tlast stalls, set by single-pass window/shift logic.
// Reset: frame state clears, registers return to standard NEC timing, both
// streams go idle.
// Stall: while the output waits, symbols without tlast keep flowing; a tlast
// symbol holds in the pipeline and backpressure reaches s_axis_tready.
module nec_ir_frame_decoder #(
  parameter int TICKS_PER_10US = necd_pkg::TICKS_PER_10US_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input symbols
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [necd_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [14:0] mark_ticks, [29:15] space_ticks
  input  logic                              s_axis_tlast,  // frame_end
  // Results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [necd_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // [7:0] command
  output logic [necd_pkg::STATUS_W-1:0]     m_axis_tuser,  // [1:0] status
  // Configuration writes
  input  logic                              cfg_wr_en,
  input  logic [necd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [necd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int TICKS_W = necd_pkg::TICKS_W;
  localparam int US_W    = $clog2(((2 ** TICKS_W) - 1) * 10 / TICKS_PER_10US + 1);
  localparam int CMP_W   = ((US_W > necd_pkg::DUR_W) ? US_W : necd_pkg::DUR_W) + 2;
  localparam int IDX_W   = necd_pkg::IDX_W;
  localparam int CMD_W   = necd_pkg::CMD_W;

  // Configuration registers
  logic [necd_pkg::DUR_W-1:0] header_mark_us;
  logic [necd_pkg::DUR_W-1:0] header_space_us;
  logic [necd_pkg::DUR_W-1:0] bit_mark_us;
  logic [necd_pkg::DUR_W-1:0] one_space_us;
  logic [necd_pkg::DUR_W-1:0] zero_space_us;
  logic [necd_pkg::TOL_W-1:0] bit_tolerance_us;
  logic [necd_pkg::TOL_W-1:0] header_tolerance_us;

  // Pipeline stages
  logic               a_valid;
  logic [TICKS_W-1:0] a_mark_ticks;
  logic [TICKS_W-1:0] a_space_ticks;
  logic               a_last;
  logic               b_valid;
  logic               b_last;
  logic [US_W-1:0]    mark_us;
  logic [US_W-1:0]    space_us;

  logic out_free;
  logic b_fire;
  logic b_take;
  logic a_fire;
  logic a_take;

  // Frame state
  logic [IDX_W-1:0] symbol_index;
  logic             header_matched;
  logic [CMD_W-1:0] shift_byte;
  logic [CMD_W-1:0] address_byte;
  logic [CMD_W-1:0] inverse_address_byte;
  logic [CMD_W-1:0] command_byte;
  logic [CMD_W-1:0] inverse_command_byte;

  logic [IDX_W-1:0] symbol_index_next;
  logic             header_matched_next;
  logic [CMD_W-1:0] shift_byte_next;
  logic [CMD_W-1:0] address_byte_next;
  logic [CMD_W-1:0] inverse_address_byte_next;
  logic [CMD_W-1:0] command_byte_next;
  logic [CMD_W-1:0] inverse_command_byte_next;

  logic                   header_ok;
  logic                   zero_ok;
  logic                   one_ok;
  logic                   space_absent;
  logic [CMD_W-1:0]       shifted_byte;
  logic [CMD_W-1:0]       result_command;
  necd_pkg::necd_status_t result_status;

  // Window test e-t <= d <= e+t, lower bound clamped at zero
  function automatic logic in_window(input logic [US_W-1:0] d,
                                     input logic [necd_pkg::DUR_W-1:0] e,
                                     input logic [necd_pkg::TOL_W-1:0] t);
    logic [CMP_W-1:0] dw;
    logic [CMP_W-1:0] ew;
    logic [CMP_W-1:0] tw;
    dw = CMP_W'(d);
    ew = CMP_W'(e);
    tw = CMP_W'(t);
    return ((dw + tw) >= ew) && (dw <= (ew + tw));
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_mark_us      <= necd_pkg::HEADER_MARK_RST;
      header_space_us     <= necd_pkg::HEADER_SPACE_RST;
      bit_mark_us         <= necd_pkg::BIT_MARK_RST;
      one_space_us        <= necd_pkg::ONE_SPACE_RST;
      zero_space_us       <= necd_pkg::ZERO_SPACE_RST;
      bit_tolerance_us    <= necd_pkg::BIT_TOL_RST;
      header_tolerance_us <= necd_pkg::HEADER_TOL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        necd_pkg::REG_HEADER_MARK:  header_mark_us      <= cfg_data;
        necd_pkg::REG_HEADER_SPACE: header_space_us     <= cfg_data;
        necd_pkg::REG_BIT_MARK:     bit_mark_us         <= cfg_data;
        necd_pkg::REG_ONE_SPACE:    one_space_us        <= cfg_data;
        necd_pkg::REG_ZERO_SPACE:   zero_space_us       <= cfg_data;
        necd_pkg::REG_BIT_TOL:      bit_tolerance_us    <= cfg_data[necd_pkg::TOL_W-1:0];
        necd_pkg::REG_HEADER_TOL:   header_tolerance_us <= cfg_data[necd_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: a stage loads when empty or when its content moves on
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign b_fire        = b_valid && (!b_last || out_free);
  assign b_take        = !b_valid || b_fire;
  assign a_fire        = a_valid && b_take;
  assign a_take        = !a_valid || a_fire;
  assign s_axis_tready = a_take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_take) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take && s_axis_tvalid) begin
      a_mark_ticks  <= s_axis_tdata[TICKS_W-1:0];
      a_space_ticks <= s_axis_tdata[2*TICKS_W-1:TICKS_W];
      a_last        <= s_axis_tlast;
    end
  end

  // Duration conversion stage
  necd_ticks_to_us #(
    .TICKS_PER_10US (TICKS_PER_10US),
    .US_W           (US_W)
  ) u_mark_conv (
    .clk   (clk),
    .load  (a_fire),
    .ticks (a_mark_ticks),
    .us    (mark_us)
  );

  necd_ticks_to_us #(
    .TICKS_PER_10US (TICKS_PER_10US),
    .US_W           (US_W)
  ) u_space_conv (
    .clk   (clk),
    .load  (a_fire),
    .ticks (a_space_ticks),
    .us    (space_us)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_take) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_last <= a_last;
    end
  end

  // Symbol classification
  assign space_absent = (space_us == '0);
  assign header_ok = in_window(mark_us, header_mark_us, header_tolerance_us) &&
                     (space_absent ||
                      in_window(space_us, header_space_us, header_tolerance_us));
  assign zero_ok   = in_window(mark_us, bit_mark_us, bit_tolerance_us) &&
                     (space_absent || in_window(space_us, zero_space_us, bit_tolerance_us));
  assign one_ok    = in_window(mark_us, bit_mark_us, bit_tolerance_us) &&
                     (space_absent || in_window(space_us, one_space_us, bit_tolerance_us));

  // LSB first: new bit enters at the top; an unmatched symbol leaves the byte alone
  always_comb begin
    if (zero_ok) begin
      shifted_byte = {1'b0, shift_byte[CMD_W-1:1]};
    end else if (one_ok) begin
      shifted_byte = {1'b1, shift_byte[CMD_W-1:1]};
    end else begin
      shifted_byte = shift_byte;
    end
  end

  // Frame state next values
  always_comb begin
    header_matched_next       = header_matched;
    shift_byte_next           = shift_byte;
    address_byte_next         = address_byte;
    inverse_address_byte_next = inverse_address_byte;
    command_byte_next         = command_byte;
    inverse_command_byte_next = inverse_command_byte;

    if (symbol_index == necd_pkg::SYM_HEADER) begin
      header_matched_next = header_ok;
    end else if (symbol_index <= necd_pkg::SYM_LAST_DATA) begin
      shift_byte_next = shifted_byte;
      // byte boundary: capture and restart the shift byte
      if (symbol_index[2:0] == 3'd0) begin
        case (symbol_index)
          necd_pkg::SYM_ADDR:     address_byte_next         = shifted_byte;
          necd_pkg::SYM_INV_ADDR: inverse_address_byte_next = shifted_byte;
          necd_pkg::SYM_CMD:      command_byte_next         = shifted_byte;
          default:                inverse_command_byte_next = shifted_byte;
        endcase
        shift_byte_next = '0;
      end
    end

    if (symbol_index < necd_pkg::SYM_MAX) begin
      symbol_index_next = symbol_index + IDX_W'(1);
    end else begin
      symbol_index_next = symbol_index;
    end
  end

  // Frame verdict from the updated state
  always_comb begin
    if (!header_matched_next) begin
      result_command = '0;
      result_status  = necd_pkg::STATUS_HEADER_MISMATCH;
    end else if ((address_byte_next != (inverse_address_byte_next ^ necd_pkg::BYTE_ONES)) ||
                 (command_byte_next != (inverse_command_byte_next ^ necd_pkg::BYTE_ONES))) begin
      result_command = '0;
      result_status  = necd_pkg::STATUS_COMPLEMENT_FAIL;
    end else begin
      result_command = command_byte_next;
      result_status  = necd_pkg::STATUS_OK;
    end
  end

  // Frame state registers; cleared after the last symbol
  always_ff @(posedge clk) begin
    if (rst || (b_fire && b_last)) begin
      symbol_index         <= '0;
      header_matched       <= 1'b0;
      shift_byte           <= '0;
      address_byte         <= '0;
      inverse_address_byte <= '0;
      command_byte         <= '0;
      inverse_command_byte <= '0;
    end else if (b_fire) begin
      symbol_index         <= symbol_index_next;
      header_matched       <= header_matched_next;
      shift_byte           <= shift_byte_next;
      address_byte         <= address_byte_next;
      inverse_address_byte <= inverse_address_byte_next;
      command_byte         <= command_byte_next;
      inverse_command_byte <= inverse_command_byte_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (b_fire && b_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_last) begin
      m_axis_tdata <= result_command;
      m_axis_tuser <= result_status;
    end
  end

`ifndef SYNTH
  // A result only ever follows a last symbol leaving the classification stage
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(b_valid && b_last))
    else $error("result issued without a last symbol");

  // The frame restarts at the header after each result
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (b_fire && b_last) |=> (symbol_index == necd_pkg::SYM_HEADER) && !header_matched)
    else $error("frame state not cleared after result");

  // Rejected frames carry a zero command
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != necd_pkg::STATUS_OK)) |-> (m_axis_tdata == '0))
    else $error("rejected frame with non-zero command");

  // Backpressure only when the input register is occupied
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> a_valid)
    else $error("input stalled with empty input register");
`endif

endmodule

@@ hw/rtl/necd_ticks_to_us.sv @@
// Registered tick-to-microsecond converter: ticks*10/TICKS_PER_10US by reciprocal multiply.
module necd_ticks_to_us #(
  parameter int TICKS_PER_10US = necd_pkg::TICKS_PER_10US_DEFAULT,
  parameter int US_W           = 19
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [necd_pkg::TICKS_W-1:0] ticks,
  output logic [US_W-1:0]            us
);

  // ticks*10 fits in TICKS_W+4 bits; multiplier is ceil(2^S/D), exact for all such values
  localparam int XW  = necd_pkg::TICKS_W + 4;
  localparam int LG  = $clog2(TICKS_PER_10US);
  localparam int S   = XW + LG;
  localparam int MW  = XW + 2;
  localparam longint unsigned MUL =
    ((longint'(1) << S) + longint'(TICKS_PER_10US) - 1) / longint'(TICKS_PER_10US);
  localparam int PW  = S + US_W;

  logic [XW-1:0]  ticks_x10;
  logic [MW-1:0]  mul_const;
  logic [PW-1:0]  product;

  // x10 as shift-add, then scale by the reciprocal
  assign ticks_x10 = XW'({ticks, 3'b000}) + XW'({ticks, 1'b0});
  assign mul_const = MW'(MUL);
  assign product   = PW'(ticks_x10) * PW'(mul_const);

  always_ff @(posedge clk) begin
    if (load) begin
      us <= product[S +: US_W];
    end
  end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the NEC IR frame decoder: symbol streams, result checks.
`timescale 1ns / 1ps

module tb;

  localparam int TICKS_W      = necd_pkg::TICKS_W;
  localparam int IDX_W        = necd_pkg::IDX_W;
  localparam int CMD_W        = necd_pkg::CMD_W;
  localparam int STATUS_W     = necd_pkg::STATUS_W;
  localparam int DUR_W        = necd_pkg::DUR_W;
  localparam int TOL_W        = necd_pkg::TOL_W;
  localparam int CFG_IDX_W    = necd_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = necd_pkg::CFG_DATA_W;
  localparam int TICKS        = necd_pkg::TICKS_PER_10US_DEFAULT;
  localparam int MAX_US       = 32767 * 10 / TICKS;  // longest duration the ticks field can express
  localparam int DRAIN_CYCLES = 8;                   // pipeline is three deep
  localparam int HOLD_CYCLES  = 300;
  localparam int SEG_ITEMS    = 70;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7; // unmapped index, must be ignored

  typedef enum int {
    CFG_NEC_DEFAULT,
    CFG_RANDOM,
    CFG_ALL_ZERO,
    CFG_ALL_ONES
  } timing_set_t;

  typedef struct packed {
    logic [CMD_W-1:0]       command;
    necd_pkg::necd_status_t status;
  } frame_result_t;

  // Scoreboard: tracks decoder state per accepted symbol and holds expected frame results
  class frame_checker;
    int hdr_mark, hdr_space, bit_mark, one_space, zero_space, bit_tol, hdr_tol;
    logic [IDX_W-1:0] sym_idx;
    bit               hdr_ok;
    logic [CMD_W-1:0] shifter, addr, addr_n, cmd, cmd_n;
    frame_result_t    pending_frames[$];
    int               errors;

    function new();
      hdr_mark     = necd_pkg::HEADER_MARK_RST;
      hdr_space    = necd_pkg::HEADER_SPACE_RST;
      bit_mark     = necd_pkg::BIT_MARK_RST;
      one_space    = necd_pkg::ONE_SPACE_RST;
      zero_space   = necd_pkg::ZERO_SPACE_RST;
      bit_tol      = necd_pkg::BIT_TOL_RST;
      hdr_tol      = necd_pkg::HEADER_TOL_RST;
      errors       = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      sym_idx = necd_pkg::SYM_HEADER;
      hdr_ok  = 1'b0;
      shifter = '0;
      addr    = '0;
      addr_n  = '0;
      cmd     = '0;
      cmd_n   = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        necd_pkg::REG_HEADER_MARK:  hdr_mark   = data;
        necd_pkg::REG_HEADER_SPACE: hdr_space  = data;
        necd_pkg::REG_BIT_MARK:     bit_mark   = data;
        necd_pkg::REG_ONE_SPACE:    one_space  = data;
        necd_pkg::REG_ZERO_SPACE:   zero_space = data;
        necd_pkg::REG_BIT_TOL:      bit_tol    = data[TOL_W-1:0];
        necd_pkg::REG_HEADER_TOL:   hdr_tol    = data[TOL_W-1:0];
        default: ;
      endcase
    endfunction

    // Lower bound may go negative; int arithmetic keeps that from wrapping
    function bit in_window(int d, int e, int t);
      return d >= e - t && d <= e + t;
    endfunction

    // A zero space counts as absent, so only the mark is judged
    function bit symbol_fits(int mark, int space, int em, int es, int t);
      return in_window(mark, em, t) && (space == 0 || in_window(space, es, t));
    endfunction

    function void note_symbol(logic [TICKS_W-1:0] mark_t, logic [TICKS_W-1:0] space_t,
                              bit last);
      int mark_us;
      int space_us;
      frame_result_t res;
      mark_us  = int'(mark_t) * 10 / TICKS;
      space_us = int'(space_t) * 10 / TICKS;
      if (sym_idx == necd_pkg::SYM_HEADER) begin
        hdr_ok = symbol_fits(mark_us, space_us, hdr_mark, hdr_space, hdr_tol);
      end else if (sym_idx <= necd_pkg::SYM_LAST_DATA) begin
        // zero wins when both windows overlap; a misfit symbol still advances the index
        if (symbol_fits(mark_us, space_us, bit_mark, zero_space, bit_tol))
          shifter = shifter >> 1;
        else if (symbol_fits(mark_us, space_us, bit_mark, one_space, bit_tol))
          shifter = (shifter >> 1) | 8'h80;
        if (sym_idx[2:0] == 3'd0) begin
          case (sym_idx)
            necd_pkg::SYM_ADDR:     addr   = shifter;
            necd_pkg::SYM_INV_ADDR: addr_n = shifter;
            necd_pkg::SYM_CMD:      cmd    = shifter;
            default:                cmd_n  = shifter;
          endcase
          shifter = '0;
        end
      end
      if (sym_idx < necd_pkg::SYM_MAX) sym_idx++;
      if (!last) return;
      if (!hdr_ok)
        res = '{command: '0, status: necd_pkg::STATUS_HEADER_MISMATCH};
      else if (addr != (addr_n ^ necd_pkg::BYTE_ONES) || cmd != (cmd_n ^ necd_pkg::BYTE_ONES))
        res = '{command: '0, status: necd_pkg::STATUS_COMPLEMENT_FAIL};
      else
        res = '{command: cmd, status: necd_pkg::STATUS_OK};
      pending_frames = {pending_frames, res};
      clear_frame();
    endfunction

    function void check_frame_result(logic [CMD_W-1:0] command, logic [STATUS_W-1:0] status);
      frame_result_t exp_res;
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result, command %0d status %0d", $time, command, status);
        errors++;
        return;
      end
      exp_res = pending_frames.pop_front();
      if (command !== exp_res.command) begin
        $display("%0t: command mismatch, expected %0d, got %0d",
                 $time, exp_res.command, command);
        errors++;
      end
      if (status !== exp_res.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d",
                 $time, exp_res.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [necd_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tlast = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [necd_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic [STATUS_W-1:0]             m_axis_tuser;
  logic                            cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0]           cfg_data = '0;

  bit           hold_off = 1'b0;
  int           src_idle_pct = 0;
  int           snk_idle_pct = 0;
  int           items_sent = 0;
  frame_checker sb = new();

  nec_ir_frame_decoder uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check on each transaction, then pick the next ready
  initial begin
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_frame_result(m_axis_tdata, m_axis_tuser);
      m_axis_tready <= !hold_off && (int'($urandom_range(0, 99)) >= snk_idle_pct);
    end
  end

  // One symbol transaction; the sender may idle at random before offering it
  task automatic send_symbol(logic [TICKS_W-1:0] mark, logic [TICKS_W-1:0] space, bit last);
    while (int'($urandom_range(0, 99)) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(necd_pkg::S_TDATA_W - 2 * TICKS_W){1'b0}}, space, mark};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_symbol(mark, space, last);
    items_sent++;
  endtask

  // Ticks for a duration scattered around a target, a little past the window either way
  function automatic logic [TICKS_W-1:0] ticks_near(int target, int tol);
    int span;
    int us;
    int tk;
    span = tol + tol / 4 + 3;
    us   = target + int'($urandom_range(0, 2 * span)) - span;
    if (us < 0) us = 0;
    if (us > MAX_US) us = MAX_US;
    tk = us * TICKS / 10 + int'($urandom_range(0, 1));
    if (tk > 32767) tk = 32767;
    return tk[TICKS_W-1:0];
  endfunction

  task automatic send_bit(bit b, bit last);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      send_symbol(TICKS_W'($urandom_range(0, 32767)), TICKS_W'($urandom_range(0, 32767)),
                  last);
    else
      send_symbol(ticks_near(sb.bit_mark, sb.bit_tol),
                  pick == 1 ? '0 : ticks_near(b ? sb.one_space : sb.zero_space, sb.bit_tol),
                  last);
  endtask

  // One frame: full, long, truncated or plain noise
  task automatic send_frame();
    int               kind;
    int               nbits;
    int               total;
    int               k;
    bit               end_on_bit;
    logic [CMD_W-1:0] frame_bytes[4];
    logic [TICKS_W-1:0] hm;
    logic [TICKS_W-1:0] hs;
    kind = $urandom_range(0, 9);
    if (kind >= 7) begin
      nbits = $urandom_range(1, 4);
      for (k = 0; k < nbits; k++)
        send_symbol(TICKS_W'($urandom_range(0, 32767)),
                    $urandom_range(0, 3) == 0 ? '0 : TICKS_W'($urandom_range(0, 32767)),
                    k == nbits - 1);
      return;
    end
    frame_bytes[0] = CMD_W'($urandom_range(0, 255));
    frame_bytes[1] = ~frame_bytes[0];
    frame_bytes[2] = CMD_W'($urandom_range(0, 255));
    frame_bytes[3] = ~frame_bytes[2];
    if ($urandom_range(0, 5) == 0)
      frame_bytes[$urandom_range(0, 3)][$urandom_range(0, 7)] ^= 1'b1;
    if ($urandom_range(0, 7) == 0) begin
      hm = TICKS_W'($urandom_range(0, 32767));
      hs = TICKS_W'($urandom_range(0, 32767));
    end else begin
      hm = ticks_near(sb.hdr_mark, sb.hdr_tol);
      hs = ticks_near(sb.hdr_space, sb.hdr_tol);
    end
    nbits      = (kind >= 5) ? $urandom_range(0, 20) : 32;
    total      = nbits + ((kind == 4) ? $urandom_range(30, 40) : 0);
    end_on_bit = (kind >= 5) || ($urandom_range(0, 3) == 0);
    send_symbol(hm, hs, total == 0);
    for (k = 0; k < total; k++)
      send_bit(k < 32 ? frame_bytes[k / 8][k % 8] : 1'($urandom_range(0, 1)),
               end_on_bit && k == total - 1);
    if (!end_on_bit)
      send_symbol(ticks_near(sb.bit_mark, sb.bit_tol), '0, 1'b1);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(index, data);
  endtask

  task automatic apply_timing(timing_set_t which);
    logic [DUR_W-1:0] hm, hs, bm, os, zs;
    logic [TOL_W-1:0] bt, ht;
    case (which)
      CFG_NEC_DEFAULT: begin
        hm = necd_pkg::HEADER_MARK_RST; bm = necd_pkg::BIT_MARK_RST;
        hs = necd_pkg::HEADER_SPACE_RST; os = necd_pkg::ONE_SPACE_RST;
        zs = necd_pkg::ZERO_SPACE_RST;
        bt = necd_pkg::BIT_TOL_RST; ht = necd_pkg::HEADER_TOL_RST;
      end
      CFG_RANDOM: begin
        hm = DUR_W'($urandom_range(2000, 30000)); hs = DUR_W'($urandom_range(1000, 20000));
        bm = DUR_W'($urandom_range(100, 3000));   os = DUR_W'($urandom_range(500, 6000));
        zs = DUR_W'($urandom_range(100, 3000));
        bt = TOL_W'($urandom_range(0, 400));      ht = TOL_W'($urandom_range(0, 1500));
      end
      CFG_ALL_ZERO: begin
        hm = '0; hs = '0; bm = '0; os = '0; zs = '0; bt = '0; ht = '0;
      end
      default: begin
        hm = '1; hs = '1; bm = '1; os = '1; zs = '1; bt = '1; ht = '1;
      end
    endcase
    write_reg(necd_pkg::REG_HEADER_MARK, hm);
    write_reg(necd_pkg::REG_HEADER_SPACE, hs);
    write_reg(necd_pkg::REG_BIT_MARK, bm);
    write_reg(necd_pkg::REG_ONE_SPACE, os);
    write_reg(necd_pkg::REG_ZERO_SPACE, zs);
    write_reg(necd_pkg::REG_BIT_TOL, {4'b0, bt});
    write_reg(necd_pkg::REG_HEADER_TOL, {4'b0, ht});
    if (which == CFG_NEC_DEFAULT)
      write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_wr_en <= 1'b0;
  endtask

  // Wait for every expected result, then let symbols that give none clear the pipeline
  task automatic wait_drained();
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_segment(timing_set_t which, bit with_hold);
    int item_start;
    wait_drained();
    apply_timing(which);
    item_start = items_sent;
    if (with_hold) begin
      fork
        begin
          hold_off <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_off <= 1'b0;
        end
      join_none
      // a burst of one-symbol frames so the block backs up behind the stalled output
      repeat (40)
        send_symbol(TICKS_W'($urandom_range(0, 32767)), TICKS_W'($urandom_range(0, 32767)),
                    1'b1);
    end
    while (items_sent - item_start < SEG_ITEMS)
      send_frame();
    s_axis_tvalid <= 1'b0;
  endtask

  // Main sequence
  initial begin
    src_idle_pct = 13;
    snk_idle_pct = 73;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: header extremes and window edges under reset timing
    send_symbol(15'd0, 15'd0, 1'b1);           // zero durations, header fails
    send_symbol(15'h7fff, 15'h7fff, 1'b1);     // longest durations, header fails
    send_symbol(15'd7200, 15'd3600, 1'b1);     // exact header, no bytes: complement fails
    send_symbol(15'd7200, 15'd0, 1'b1);        // header with no space: space not judged
    send_symbol(15'd7040, 15'd3600, 1'b1);     // mark at lower window edge
    send_symbol(15'd7039, 15'd3600, 1'b1);     // just under it
    send_symbol(15'd7361, 15'd3600, 1'b1);     // just over the upper edge
    send_symbol(15'd7200, 15'd3761, 1'b1);     // space just over the upper edge
    send_symbol(15'd7360, 15'd3440, 1'b0);     // upper mark edge, lower space edge
    send_symbol(15'd448, 15'd448, 1'b0);       // zero bit
    send_symbol(15'd448, 15'd1352, 1'b0);      // one bit
    send_symbol(15'd448, 15'd800, 1'b0);       // fits neither, byte untouched
    send_symbol(15'd448, 15'd0, 1'b0);         // no space: taken as a zero
    send_symbol(15'h7fff, 15'd1352, 1'b0);     // mark far off
    send_symbol(15'd0, 15'h7fff, 1'b1);        // short frame ends here
    s_axis_tvalid <= 1'b0;

    run_segment(CFG_NEC_DEFAULT, 1'b0);
    run_segment(CFG_RANDOM, 1'b0);
    src_idle_pct = 73;
    snk_idle_pct = 13;
    run_segment(CFG_ALL_ZERO, 1'b0);
    run_segment(CFG_RANDOM, 1'b0);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_segment(CFG_ALL_ONES, 1'b0);
    run_segment(CFG_NEC_DEFAULT, 1'b1);
    wait_drained();

    if (sb.errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
